// File: hdl/rlsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rlsu_pkg
// Shared types and constants of the run-limited sequence unranker: register
// indexes, field widths and the command/status bundle between the sequencer
// and the datapath.
// -----------------------------------------------------------------------------
package rlsu_pkg;

	localparam int RANK_W   = 64;
	localparam int LETTER_W = 5;
	localparam int ALPHA_W  = 5;
	localparam int RUNCFG_W = 5;
	localparam int LENCFG_W = 6;
	localparam int CFG_W    = 6;
	localparam int CIDX_W   = 2;

	localparam logic [LETTER_W-1:0] LETTERS = LETTER_W'(26);

	localparam logic [CIDX_W-1:0] REG_ALPHABET_SIZE = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] REG_MAX_RUN       = CIDX_W'(1);
	localparam logic [CIDX_W-1:0] REG_STRING_LENGTH = CIDX_W'(2);

	localparam logic [ALPHA_W-1:0]  RST_ALPHABET_SIZE = ALPHA_W'(2);
	localparam logic [RUNCFG_W-1:0] RST_MAX_RUN       = RUNCFG_W'(2);
	localparam logic [LENCFG_W-1:0] RST_STRING_LENGTH = LENCFG_W'(8);

	localparam logic [RANK_W-1:0] COUNT_SAT = '1;

	typedef struct packed {
		logic start;
		logic fill0;
		logic next_row;
		logic row_rd;
		logic row_mul;
		logic row_fill;
		logic walk_init;
		logic walk;
		logic set_err;
		logic emit_init;
		logic emit_rd;
		logic emit_next;
	} cmd_t;

	typedef struct packed {
		logic a_last;
		logic m_last;
		logic found;
		logic miss_last;
		logic pos_last;
	} stat_t;

endpackage
`default_nettype wire

// File: hdl/rlsu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rlsu_ctrl
// Sequencer: steps through table fill, letter walk and word emission.
// -----------------------------------------------------------------------------
module rlsu_ctrl (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  wire             out_stall,
	output rlsu_pkg::cmd_t  cmd,
	input  rlsu_pkg::stat_t stat
);
	import rlsu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_FILL0,
		S_ROW_RD,
		S_ROW_MUL,
		S_ROW_FILL,
		S_WALK,
		S_EMIT_RD,
		S_EMIT_WAIT,
		S_ERR_WAIT
	} state_t;

	state_t state_q, state_d;
	logic   valid_q, valid_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		valid_d = valid_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_FILL0;
				end
			end
			S_FILL0, S_ROW_FILL: begin
				cmd.fill0    = (state_q == S_FILL0);
				cmd.row_fill = (state_q == S_ROW_FILL);
				if (stat.a_last) begin
					if (stat.m_last) begin
						cmd.walk_init = 1'b1;
						state_d       = S_WALK;
					end else begin
						cmd.next_row = 1'b1;
						state_d      = S_ROW_RD;
					end
				end
			end
			S_ROW_RD: begin
				cmd.row_rd = 1'b1;
				state_d    = S_ROW_MUL;
			end
			S_ROW_MUL: begin
				cmd.row_mul = 1'b1;
				state_d     = S_ROW_FILL;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.miss_last) begin
					cmd.set_err = 1'b1;
					valid_d     = 1'b1;
					state_d     = S_ERR_WAIT;
				end else if (stat.found && stat.pos_last) begin
					cmd.emit_init = 1'b1;
					state_d       = S_EMIT_RD;
				end
			end
			S_EMIT_RD: begin
				cmd.emit_rd = 1'b1;
				valid_d     = 1'b1;
				state_d     = S_EMIT_WAIT;
			end
			S_EMIT_WAIT: begin
				if (!out_stall) begin
					valid_d = 1'b0;
					if (stat.pos_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.emit_next = 1'b1;
						state_d       = S_EMIT_RD;
					end
				end
			end
			S_ERR_WAIT: begin
				if (!out_stall) begin
					valid_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
				valid_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= valid_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = valid_q;

endmodule
`default_nettype wire

// File: hdl/rlsu_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rlsu_dp
// Datapath: configuration registers, count table memory with its saturating
// multiply/add, rank walk with a one-deep read pipeline, letter buffer.
// -----------------------------------------------------------------------------
module rlsu_dp #(
	parameter int MAX_LENGTH = 32,
	parameter int MAX_RUN    = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [rlsu_pkg::CIDX_W-1:0]          cfg_index,
	input  wire  [rlsu_pkg::CFG_W-1:0]           cfg_wdata,
	input  wire  [rlsu_pkg::RANK_W-1:0]          rank,
	input  rlsu_pkg::cmd_t                       cmd,
	output rlsu_pkg::stat_t                      stat,
	output logic [rlsu_pkg::LETTER_W-1:0]        letter_index,
	output logic                                 last,
	output logic                                 rank_too_large
);
	import rlsu_pkg::*;

	localparam int ROW_W     = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam int LEN_W     = $clog2(MAX_LENGTH + 1);
	localparam int RUN_W     = $clog2(MAX_RUN + 1);
	localparam int TBL_DEPTH = MAX_LENGTH * MAX_RUN;
	localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
	localparam int CMP_W     = 8;

	// configuration
	logic [ALPHA_W-1:0]  alpha_q;
	logic [RUNCFG_W-1:0] runcfg_q;
	logic [LENCFG_W-1:0] lencfg_q;

	logic [LETTER_W-1:0] letters;
	logic [RUN_W-1:0]    run;
	logic [LEN_W-1:0]    len;
	logic [ROW_W-1:0]    last_row;

	// count table
	logic [RANK_W-1:0] tbl_mem [TBL_DEPTH];
	logic [RANK_W-1:0] tbl_rd_q;
	logic              tbl_we, tbl_re;
	logic [ADDR_W-1:0] tbl_waddr, tbl_raddr;
	logic [RANK_W-1:0] tbl_wdata;

	// fill
	logic [ROW_W-1:0]   m_q, m_prev;
	logic [RUN_W-1:0]   a_q;
	logic [RANK_W-1:0]  fresh_q;
	logic [RANK_W+4:0]  prod;
	logic [RANK_W-1:0]  fresh;
	logic [RANK_W-1:0]  same;
	logic [RANK_W:0]    sum;

	// walk
	logic [RANK_W-1:0]   n_q;
	logic [ROW_W-1:0]    pos_q, rem;
	logic [LETTER_W-1:0] i_q, prev_q, letter_s1;
	logic [RUN_W-1:0]    cur_q, na_s1, na_issue, na_addr;
	logic                pend_s1, issue_en;
	logic [RANK_W-1:0]   way;
	logic                hit, miss;
	logic                err_q;

	// letter buffer
	logic [LETTER_W-1:0] buf_mem [MAX_LENGTH];
	logic [LETTER_W-1:0] buf_rd_q;

	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [ROW_W-1:0] row,
			input logic [RUN_W-1:0] a);
		logic [ADDR_W:0] t;
		t = (ADDR_W+1)'(row) * (ADDR_W+1)'(MAX_RUN) + (ADDR_W+1)'(a) - (ADDR_W+1)'(1);
		return t[ADDR_W-1:0];
	endfunction

	// clamp registers into their meaningful ranges
	always_comb begin
		if (alpha_q == '0)
			letters = LETTER_W'(1);
		else if (alpha_q > LETTERS)
			letters = LETTERS;
		else
			letters = alpha_q;

		if (runcfg_q == '0)
			run = RUN_W'(1);
		else if (CMP_W'(runcfg_q) > CMP_W'(MAX_RUN))
			run = RUN_W'(MAX_RUN);
		else
			run = RUN_W'(runcfg_q);

		if (lencfg_q == '0)
			len = LEN_W'(1);
		else if (CMP_W'(lencfg_q) > CMP_W'(MAX_LENGTH))
			len = LEN_W'(MAX_LENGTH);
		else
			len = LEN_W'(lencfg_q);
	end

	assign last_row = ROW_W'(len - LEN_W'(1));
	assign m_prev   = m_q - ROW_W'(1);
	assign rem      = last_row - pos_q;

	// saturating fresh-run count of one row
	assign prod  = (RANK_W+5)'(letters - LETTER_W'(1)) * (RANK_W+5)'(tbl_rd_q);
	assign fresh = (|prod[RANK_W+4:RANK_W]) ? COUNT_SAT : prod[RANK_W-1:0];
	assign same  = (a_q == RUN_W'(1)) ? '0 : tbl_rd_q;
	assign sum   = {1'b0, same} + {1'b0, fresh_q};

	// walk: na for the letter being issued, compare for the one in flight
	assign na_issue = ((pos_q != '0) && (i_q == prev_q)) ? cur_q - RUN_W'(1) : run;
	assign na_addr  = (na_issue == '0) ? RUN_W'(1) : na_issue;
	assign way      = (na_s1 == '0) ? '0 : tbl_rd_q;
	assign hit      = cmd.walk && pend_s1 && (way >= n_q);
	assign miss     = cmd.walk && pend_s1 && (way < n_q);
	assign issue_en = cmd.walk && !hit && (i_q < letters);

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = tbl_addr(m_q, a_q);
		tbl_wdata = sum[RANK_W] ? COUNT_SAT : sum[RANK_W-1:0];
		if (cmd.fill0) begin
			tbl_we    = 1'b1;
			tbl_wdata = RANK_W'(1);
		end else if (cmd.row_fill) begin
			tbl_we = 1'b1;
		end

		tbl_re    = 1'b0;
		tbl_raddr = tbl_addr(rem, na_addr);
		if (cmd.row_rd) begin
			tbl_re    = 1'b1;
			tbl_raddr = tbl_addr(m_prev, run);
		end else if (cmd.row_fill) begin
			tbl_re    = 1'b1;
			tbl_raddr = tbl_addr(m_prev, a_q);
		end else if (issue_en) begin
			tbl_re = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_waddr] <= tbl_wdata;
		if (tbl_re)
			tbl_rd_q <= tbl_mem[tbl_raddr];
	end

	always_ff @(posedge clk) begin
		if (hit)
			buf_mem[pos_q] <= letter_s1;
		if (cmd.emit_rd)
			buf_rd_q <= buf_mem[pos_q];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start)
			n_q <= (rank == '0) ? RANK_W'(1) : rank;
		else if (miss)
			n_q <= n_q - way;
		if (cmd.row_mul)
			fresh_q <= fresh;
		if (issue_en) begin
			letter_s1 <= i_q;
			na_s1     <= na_issue;
		end
		if (hit) begin
			prev_q <= letter_s1;
			cur_q  <= na_s1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q  <= RST_ALPHABET_SIZE;
			runcfg_q <= RST_MAX_RUN;
			lencfg_q <= RST_STRING_LENGTH;
			m_q      <= '0;
			a_q      <= RUN_W'(1);
			pos_q    <= '0;
			i_q      <= '0;
			pend_s1  <= 1'b0;
			err_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ALPHABET_SIZE: alpha_q  <= cfg_wdata[ALPHA_W-1:0];
					REG_MAX_RUN:       runcfg_q <= cfg_wdata[RUNCFG_W-1:0];
					REG_STRING_LENGTH: lencfg_q <= cfg_wdata[LENCFG_W-1:0];
					default: ;
				endcase
			end

			if (cmd.start) begin
				m_q   <= '0;
				a_q   <= RUN_W'(1);
				err_q <= 1'b0;
			end else begin
				if (cmd.fill0 || cmd.row_fill)
					a_q <= stat.a_last ? RUN_W'(1) : a_q + RUN_W'(1);
				if (cmd.next_row)
					m_q <= m_q + ROW_W'(1);
			end

			if (cmd.set_err)
				err_q <= 1'b1;

			// restart the letter scan on each new position
			if (cmd.walk_init || hit)
				i_q <= '0;
			else if (issue_en)
				i_q <= i_q + LETTER_W'(1);
			pend_s1 <= issue_en && !cmd.walk_init;

			if (cmd.walk_init || cmd.emit_init)
				pos_q <= '0;
			else if (hit || cmd.emit_next)
				pos_q <= pos_q + ROW_W'(1);
		end
	end

	assign stat.a_last    = (a_q == run);
	assign stat.m_last    = (m_q == last_row);
	assign stat.found     = hit;
	assign stat.miss_last = miss && (letter_s1 == letters - LETTER_W'(1));
	assign stat.pos_last  = (pos_q == last_row);

	assign letter_index   = err_q ? '0 : buf_rd_q;
	assign last           = err_q || (pos_q == last_row);
	assign rank_too_large = err_q;

endmodule
`default_nettype wire

// File: hdl/run_limited_sequence_unranker.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequence: the count table is rebuilt row by row for each rank, then the
//   letter walk does one table read per letter tried, then each word is
//   read from the letter buffer and held on the output until taken.
// Throughput: one rank at a time, taken only while the sequencer is idle;
//   the single read port of the count table sets the pace.
// Reset: arst_n idles the sequencer and loads alphabet_size=2, max_run=2, string_length=8.
// -----------------------------------------------------------------------------
// run_limited_sequence_unranker
// Returns the rank-th string, in lexicographic order, of all strings over the
// first alphabet_size letters with no run longer than max_run, one word per
// letter.
// -----------------------------------------------------------------------------
module run_limited_sequence_unranker #(
	parameter int MAX_LENGTH = 32,
	parameter int MAX_RUN    = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// configuration write port
	input  wire                                cfg_we,
	input  wire  [rlsu_pkg::CIDX_W-1:0]        cfg_index,
	input  wire  [rlsu_pkg::CFG_W-1:0]         cfg_wdata,
	// rank words in
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [rlsu_pkg::RANK_W-1:0]        rank,
	// letter words out
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [rlsu_pkg::LETTER_W-1:0]      letter_index,
	output logic                               last,
	output logic                               rank_too_large
);
	import rlsu_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// Sequencer: hold off input while a rank is in work, and walk the
	// phases fill -> walk -> emit (or a single error word when the rank
	// runs past the last letter of some position).
	rlsu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Datapath: rebuild the count table row by row (one saturating
	// multiply per row, one saturating add per entry), then subtract
	// counts from the rank letter by letter, and buffer the chosen letters
	// until the walk succeeds.
	rlsu_dp #(
		.MAX_LENGTH (MAX_LENGTH),
		.MAX_RUN    (MAX_RUN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.rank           (rank),
		.cmd            (cmd),
		.stat           (stat),
		.letter_index   (letter_index),
		.last           (last),
		.rank_too_large (rank_too_large)
	);

endmodule
`default_nettype wire

// File: hdl/rlsu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rlsu_checker
// Port-level checks of the unranker, bound to the top level.
// -----------------------------------------------------------------------------
module rlsu_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               in_valid,
	input wire                               in_stall,
	input wire [rlsu_pkg::LETTER_W-1:0]      letter_index,
	input wire                               out_valid,
	input wire                               out_stall,
	input wire                               last,
	input wire                               rank_too_large
);
	import rlsu_pkg::*;

	// a taken rank keeps the input side closed on the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a rank was taken");

	// no rank enters while result words are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result word waits");

	// the final word closes the output side
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid)
		else $error("output word after the final word");

	// an error word is a lone final word for letter A
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rank_too_large |-> last && (letter_index == '0))
		else $error("malformed error word");

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(letter_index) && $stable(last)
			&& $stable(rank_too_large))
		else $error("stalled output word changed");

endmodule

bind run_limited_sequence_unranker rlsu_checker u_rlsu_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.letter_index   (letter_index),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.last           (last),
	.rank_too_large (rank_too_large)
);
`default_nettype wire
